>>> rtl/spq_pkg.sv
// shared constants, codes and types of the sorted priority queue
`default_nettype none

package spq_pkg;

  // store geometry and field widths
  localparam int DEPTH = 16;
  localparam int PRI_W = 8;
  localparam int PID_W = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // operation codes
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_PRI = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: controller plus entry datapath
//
//   channel  handshake               payload
//   input    in_valid / in_ready     cmd, priority_req, process_id
//   output   out_valid / out_ready   status, out_priority, out_process_id,
//                                    head_valid, head_priority, head_process_id,
//                                    entry_count
//
// each beat is handled in two steps: the idle state captures it and the execute
// state compares it against every stored entry in parallel and shifts the store;
// no new beat is taken before the last has executed; a finished result waits in the
// output register while the next beat is captured, and the execute step holds until it is free
// reset clears the controller, the output valid and the entry count; the store
// itself is not cleared, entries beyond the count are never shown
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             cmd,
  input  wire logic [PRI_W-1:0] priority_req,
  input  wire logic [PID_W-1:0] process_id,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            status,
  output logic [PRI_W-1:0]      out_priority,
  output logic [PID_W-1:0]      out_process_id,
  output logic                  head_valid,
  output logic [PRI_W-1:0]      head_priority,
  output logic [PID_W-1:0]      head_process_id,
  output logic [CNT_W-1:0]      entry_count
);

  ctl_cmd_t ctl;

  // sequencing
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // store and result
  spq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .cmd             (cmd),
    .priority_req    (priority_req),
    .process_id      (process_id),
    .status          (status),
    .out_priority    (out_priority),
    .out_process_id  (out_process_id),
    .head_valid      (head_valid),
    .head_priority   (head_priority),
    .head_process_id (head_process_id),
    .entry_count     (entry_count)
  );

`ifndef SYNTHESIS
  // an accepted beat is being worked on, so no second beat the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a beat is in flight");

  // head flag agrees with the count
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head_valid == (entry_count != '0)))
    else $error("head_valid disagrees with entry_count");

  // count never exceeds the store depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= CNT_W'(DEPTH)))
    else $error("entry_count beyond depth");

  // only nonzero priorities are ever stored
  a_head_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && head_valid) |-> (head_priority != '0))
    else $error("stored head has zero priority");
`endif

endmodule

`default_nettype wire

>>> rtl/spq_datapath.sv
// sorted entry store with parallel compare, shift insert/remove and result register
`default_nettype none

module spq_datapath
  import spq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctl_cmd_t         ctl,
  input  wire logic             cmd,
  input  wire logic [PRI_W-1:0] priority_req,
  input  wire logic [PID_W-1:0] process_id,
  output logic [1:0]            status,
  output logic [PRI_W-1:0]      out_priority,
  output logic [PID_W-1:0]      out_process_id,
  output logic                  head_valid,
  output logic [PRI_W-1:0]      head_priority,
  output logic [PID_W-1:0]      head_process_id,
  output logic [CNT_W-1:0]      entry_count
);

  // captured input beat
  op_t             cmd_q;
  logic [PRI_W-1:0] pri_q;
  logic [PID_W-1:0] pid_q;

  // sorted store, entry 0 is the head
  logic [PRI_W-1:0] pri_mem [DEPTH];
  logic [PID_W-1:0] pid_mem [DEPTH];
  logic [CNT_W-1:0] count;

  logic [PRI_W-1:0] pri_ins [DEPTH];
  logic [PID_W-1:0] pid_ins [DEPTH];
  logic [PRI_W-1:0] pri_rem [DEPTH];
  logic [PID_W-1:0] pid_rem [DEPTH];
  logic [PRI_W-1:0] pri_next [DEPTH];
  logic [PID_W-1:0] pid_next [DEPTH];
  logic [CNT_W-1:0] count_next;
  logic [DEPTH-1:0] le;

  status_t          st;
  logic [PRI_W-1:0] opri;
  logic [PID_W-1:0] opid;

  // per-cell compare and shift choices
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign le[i] = (CNT_W'(i) < count) && (pri_mem[i] <= pri_q);

    if (i == 0) begin : g_first
      always_comb begin
        if (le[i]) begin
          pri_ins[i] = pri_mem[i];
          pid_ins[i] = pid_mem[i];
        end else begin
          pri_ins[i] = pri_q;
          pid_ins[i] = pid_q;
        end
      end
    end else begin : g_rest
      always_comb begin
        if (le[i]) begin
          pri_ins[i] = pri_mem[i];
          pid_ins[i] = pid_mem[i];
        end else if (le[i-1]) begin
          pri_ins[i] = pri_q;
          pid_ins[i] = pid_q;
        end else begin
          pri_ins[i] = pri_mem[i-1];
          pid_ins[i] = pid_mem[i-1];
        end
      end
    end

    if (i == DEPTH - 1) begin : g_last
      assign pri_rem[i] = pri_mem[i];
      assign pid_rem[i] = pid_mem[i];
    end else begin : g_mid
      assign pri_rem[i] = pri_mem[i+1];
      assign pid_rem[i] = pid_mem[i+1];
    end
  end

  // operation decode and next store contents
  always_comb begin
    st         = ST_OK;
    opri       = '0;
    opid       = '0;
    count_next = count;
    pri_next   = pri_mem;
    pid_next   = pid_mem;
    case (cmd_q)
      OP_ENQ: begin
        if (pri_q == '0) begin
          st = ST_BAD_PRI;
        end else if (count == CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else begin
          pri_next   = pri_ins;
          pid_next   = pid_ins;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else begin
          opri       = pri_mem[0];
          opid       = pid_mem[0];
          pri_next   = pri_rem;
          pid_next   = pid_rem;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // input capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= op_t'(cmd);
      pri_q <= priority_req;
      pid_q <= process_id;
    end
  end

  // store update
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      pri_mem <= pri_next;
      pid_mem <= pid_next;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.exec) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status          <= st;
      out_priority    <= opri;
      out_process_id  <= opid;
      head_valid      <= (count_next != '0);
      head_priority   <= (count_next != '0) ? pri_next[0] : '0;
      head_process_id <= (count_next != '0) ? pid_next[0] : '0;
      entry_count     <= count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/spq_ctrl.sv
// controller: input capture, execute step and output valid
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ctl_cmd_t  ctl
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ctl.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
